// ===== src/bphd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bphd_pkg;

    // Widths of the word fields and the configuration registers.
    localparam int FIELD_WIDTH     = 6;
    localparam int TICK_WIDTH      = 10;
    localparam int THRESH_WIDTH    = 15;
    localparam int CFG_DATA_WIDTH  = 15;
    localparam int CFG_INDEX_WIDTH = 2;

    // Defaults for the top-level parameters.
    localparam int BUTTON_COUNT_DEFAULT = 6;
    localparam int COUNT_WIDTH_DEFAULT  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TICK_MS        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_THRESHOLD  = 2'd2;

    // Register values after reset.
    localparam logic [TICK_WIDTH-1:0]   TICK_MS_RESET   = 10'd10;
    localparam logic [THRESH_WIDTH-1:0] PRESS_THR_RESET = 15'd50;
    localparam logic [THRESH_WIDTH-1:0] HOLD_THR_RESET  = 15'd1000;

    // Input word modes.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ===== src/button_press_hold_detector_top.sv =====
// Button press and hold detector.
// Input channel (in_valid / in_stall) carries one word per tick: mode and
// pin_levels. A tick word compares each active-low pin with its previous level,
// times how long it stays low in steps of tick_ms, flags a hold once the low
// time reaches hold_threshold_ms, and on release of an unheld button sets a
// sticky pressed flag if the low time reached press_threshold_ms. A clear word
// zeroes every pressed flag. Each input word gives one output word (out_valid /
// out_stall) with the pressed, held and level masks after that word's update.
// The configuration port (cfg_write, cfg_index, cfg_data) writes one register
// per cycle and should only be used while no word is in flight.
// A word accepted is registered in the input stage, and its result is registered
// in the output stage once that stage is free, which raises out_valid.
// Throughput: one word per cycle unless the receiver stalls; every button is
// updated in parallel by one add and two compares between the input register
// and the result register. When the receiver stalls, the result is held, one
// further word waits in the input register, and in_stall rises once both are
// occupied. Reset clears all flags, levels and low-time counters, empties
// both stages and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module button_press_hold_detector_top #(
    parameter int BUTTON_COUNT = bphd_pkg::BUTTON_COUNT_DEFAULT,
    parameter int COUNT_WIDTH  = bphd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   mode,
    input  wire logic [bphd_pkg::FIELD_WIDTH-1:0]       pin_levels,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [bphd_pkg::FIELD_WIDTH-1:0]            pressed_mask,
    output logic [bphd_pkg::FIELD_WIDTH-1:0]            held_mask,
    output logic [bphd_pkg::FIELD_WIDTH-1:0]            level_mask,
    input  wire logic                                   cfg_write,
    input  wire logic [bphd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [bphd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int FW     = bphd_pkg::FIELD_WIDTH;
    localparam int PAD_W  = (BUTTON_COUNT > FW) ? BUTTON_COUNT : FW;
    localparam int WIDE_W = (COUNT_WIDTH > bphd_pkg::THRESH_WIDTH)
                            ? COUNT_WIDTH : bphd_pkg::THRESH_WIDTH;
    localparam int CALC_W = WIDE_W + 1;

    // Configuration registers.
    logic [bphd_pkg::TICK_WIDTH-1:0]   tick_ms_reg;
    logic [bphd_pkg::THRESH_WIDTH-1:0] press_thr_reg;
    logic [bphd_pkg::THRESH_WIDTH-1:0] hold_thr_reg;

    // Input stage.
    logic          in_valid_reg;
    logic          mode_reg;
    logic [FW-1:0] pin_levels_reg;

    // Button state.
    logic [COUNT_WIDTH-1:0]  low_time_reg  [BUTTON_COUNT];
    logic [COUNT_WIDTH-1:0]  low_time_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] last_levels_reg, last_levels_next;
    logic [BUTTON_COUNT-1:0] held_reg, held_next;
    logic [BUTTON_COUNT-1:0] pressed_reg, pressed_next;

    // Output stage.
    logic          out_valid_reg;
    logic [FW-1:0] pressed_mask_reg, pressed_mask_next;
    logic [FW-1:0] held_mask_reg, held_mask_next;
    logic [FW-1:0] level_mask_reg, level_mask_next;

    logic in_fire;
    logic out_free;
    logic stage_fire;

    // Handshake: the output register frees when empty or being taken.
    assign out_free   = !out_valid_reg || !out_stall;
    assign stage_fire = in_valid_reg && out_free;
    assign in_stall   = in_valid_reg && !out_free;
    assign in_fire    = in_valid && !in_stall;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg   <= bphd_pkg::TICK_MS_RESET;
            press_thr_reg <= bphd_pkg::PRESS_THR_RESET;
            hold_thr_reg  <= bphd_pkg::HOLD_THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bphd_pkg::CFG_TICK_MS:
                    tick_ms_reg <= cfg_data[bphd_pkg::TICK_WIDTH-1:0];
                bphd_pkg::CFG_PRESS_THRESHOLD:
                    press_thr_reg <= cfg_data[bphd_pkg::THRESH_WIDTH-1:0];
                bphd_pkg::CFG_HOLD_THRESHOLD:
                    hold_thr_reg <= cfg_data[bphd_pkg::THRESH_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    // Per-button update of the word held in the input stage.
    always_comb
    begin
        logic [PAD_W-1:0]        levels_pad;
        logic [BUTTON_COUNT-1:0] levels;
        logic [CALC_W-1:0]       sum;
        logic [PAD_W-1:0]        pressed_pad;
        logic [PAD_W-1:0]        held_pad;
        logic [PAD_W-1:0]        last_pad;

        // Pins beyond the field width read as low.
        levels_pad       = PAD_W'(pin_levels_reg);
        levels           = levels_pad[BUTTON_COUNT-1:0];
        low_time_next    = low_time_reg;
        last_levels_next = last_levels_reg;
        held_next        = held_reg;
        pressed_next     = pressed_reg;
        sum              = '0;

        if (mode_reg == bphd_pkg::MODE_CLEAR)
        begin
            pressed_next = '0;
        end
        else
        begin
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                sum = CALC_W'(low_time_reg[b]) + CALC_W'(tick_ms_reg);
                if (levels[b])
                begin
                    // Release: a held button only drops its hold.
                    if (!last_levels_reg[b])
                    begin
                        if (held_reg[b])
                            held_next[b] = 1'b0;
                        else if (CALC_W'(low_time_reg[b]) >= CALC_W'(press_thr_reg))
                            pressed_next[b] = 1'b1;
                    end
                end
                else if (last_levels_reg[b])
                begin
                    // Fall: start timing afresh.
                    low_time_next[b] = '0;
                end
                else if (CALC_W'(low_time_reg[b]) < CALC_W'(hold_thr_reg))
                begin
                    // Still low: count up, saturating at full scale.
                    if (sum[CALC_W-1:COUNT_WIDTH] != '0)
                        low_time_next[b] = '1;
                    else
                        low_time_next[b] = sum[COUNT_WIDTH-1:0];
                end
                else
                begin
                    held_next[b] = 1'b1;
                end
            end
            last_levels_next = levels;
        end

        // Masks cut or padded to the field width.
        pressed_pad       = PAD_W'(pressed_next);
        held_pad          = PAD_W'(held_next);
        last_pad          = PAD_W'(last_levels_next);
        pressed_mask_next = pressed_pad[FW-1:0];
        held_mask_next    = held_pad[FW-1:0];
        level_mask_next   = last_pad[FW-1:0];
    end

    // Control and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_levels_reg <= '0;
            held_reg        <= '0;
            pressed_reg     <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++)
                low_time_reg[b] <= '0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (stage_fire)
                in_valid_reg <= 1'b0;

            if (stage_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (stage_fire)
            begin
                last_levels_reg <= last_levels_next;
                held_reg        <= held_next;
                pressed_reg     <= pressed_next;
                low_time_reg    <= low_time_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg       <= mode;
            pin_levels_reg <= pin_levels;
        end
        if (stage_fire)
        begin
            pressed_mask_reg <= pressed_mask_next;
            held_mask_reg    <= held_mask_next;
            level_mask_reg   <= level_mask_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pressed_mask = pressed_mask_reg;
    assign held_mask    = held_mask_reg;
    assign level_mask   = level_mask_reg;

    // A held button is always one whose last level was low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg & last_levels_reg) == '0)
    else $error("held flag set on a button whose level is high");

    // A clear word leaves every pressed flag at zero in its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && mode_reg == bphd_pkg::MODE_CLEAR)
        |=> (out_valid && pressed_mask == '0))
    else $error("clear word did not zero the pressed mask");

    // Tick words never drop a pressed flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && mode_reg == bphd_pkg::MODE_TICK)
        |=> ((pressed_reg & $past(pressed_reg)) == $past(pressed_reg)))
    else $error("tick word cleared a sticky pressed flag");

    // The input side only stalls while its stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
    else $error("input stalled with an empty input stage");

endmodule

`default_nettype wire
